// File: sv/qrfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qrfr_pkg;

  // Number of symbols in one frame report, and the place of the split marker.
  localparam int unsigned ReportLen = 19;
  localparam int unsigned IdxW = 5;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ReportLen - 1);
  // The first ten symbols carry the button groups, with inverted polarity.
  localparam logic [IdxW-1:0] ButtonSyms = IdxW'(10);

  typedef enum logic [1:0] {
    SYM_ZERO  = 2'd0,
    SYM_ONE   = 2'd1,
    SYM_SPLIT = 2'd2
  } sym_e;

  // Snapshot taken on a frame tick; bit 0 is the first symbol to be sent.
  typedef struct packed {
    logic [7:0] roll_count;
    logic [4:0] group_second;
    logic [4:0] group_first;
  } report_t;

  function automatic sym_e report_symbol(report_t rep, logic [IdxW-1:0] idx);
    logic [$bits(report_t)-1:0] bits;
    logic                       bit_val;
    sym_e                       sym;
    bits    = rep;
    bit_val = (idx < LastIdx) ? bits[idx] : 1'b0;
    if (idx == LastIdx) begin
      sym = SYM_SPLIT;
    end else if (idx < ButtonSyms) begin
      sym = bit_val ? SYM_ZERO : SYM_ONE;
    end else begin
      sym = bit_val ? SYM_ONE : SYM_ZERO;
    end
    return sym;
  endfunction

endpackage

`default_nettype wire

// File: sv/qrfr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module qrfr_front import qrfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic       phase_a_i,
  input  wire logic       phase_b_i,
  input  wire logic       strobe_first_i,
  input  wire logic       strobe_second_i,
  input  wire logic [4:0] button_lines_i,
  input  wire logic       frame_tick_i,
  output logic            rep_valid_o,
  output report_t         rep_o
);

  logic       prev_a_q, prev_b_q, primed_q;
  logic       prev_s1_q, prev_s2_q;
  logic [7:0] count_q, count_d, count_step;
  logic [4:0] grp1_q, grp1_d, grp2_q, grp2_d;
  logic       change_a, change_b;

  assign change_a = phase_a_i ^ prev_a_q;
  assign change_b = phase_b_i ^ prev_b_q;

  // A change on both phases at once is ignored; only the levels are reloaded.
  always_comb begin
    count_step = count_q;
    if (primed_q) begin
      if (change_a && !change_b) begin
        count_step = (phase_a_i != phase_b_i) ? count_q + 8'd1 : count_q - 8'd1;
      end else if (change_b && !change_a) begin
        count_step = (phase_b_i == phase_a_i) ? count_q + 8'd1 : count_q - 8'd1;
      end
    end
  end

  assign grp1_d  = (strobe_first_i && !prev_s1_q) ? button_lines_i : grp1_q;
  assign grp2_d  = (strobe_second_i && !prev_s2_q) ? button_lines_i : grp2_q;
  assign count_d = frame_tick_i ? 8'd0 : count_step;

  assign rep_valid_o       = accept_i && frame_tick_i;
  assign rep_o.roll_count   = count_step;
  assign rep_o.group_second = grp2_d;
  assign rep_o.group_first  = grp1_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q  <= 1'b0;
      prev_b_q  <= 1'b0;
      primed_q  <= 1'b0;
      prev_s1_q <= 1'b0;
      prev_s2_q <= 1'b0;
      count_q   <= 8'd0;
      grp1_q    <= 5'd0;
      grp2_q    <= 5'd0;
    end else if (accept_i) begin
      prev_a_q  <= phase_a_i;
      prev_b_q  <= phase_b_i;
      primed_q  <= 1'b1;
      prev_s1_q <= strobe_first_i;
      prev_s2_q <= strobe_second_i;
      count_q   <= count_d;
      grp1_q    <= grp1_d;
      grp2_q    <= grp2_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/qrfr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module qrfr_fifo import qrfr_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_i,
  input  report_t      wr_data_i,
  input  wire logic    rd_i,
  output logic         full_o,
  output logic         valid_o,
  output report_t      rd_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  report_t        slot_q [Depth];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = slot_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/qrfr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module qrfr_back import qrfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  report_t         head_i,
  output logic            head_take_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [1:0]      symbol_o,
  output logic            last_o
);

  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  report_t         rep_q;
  logic            beat_out, at_last;

  assign at_last  = (idx_q == LastIdx);
  assign beat_out = busy_q && pop_i;
  // The next report is loaded in the cycle the split marker leaves.
  assign head_take_o = head_valid_i && (!busy_q || (beat_out && at_last));

  assign empty_o  = !busy_q;
  assign symbol_o = report_symbol(rep_q, idx_q);
  assign last_o   = at_last;

  always_ff @(posedge clk_i) begin
    if (head_take_o) begin
      rep_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (head_take_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (beat_out) begin
      if (at_last) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/quadrature_roller_frame_reporter.sv
// Roller frame reporter: x4 quadrature decoding of a roller with button capture.
// Input channel (push / full): one beat is one sample of both phase lines,
// both strobe lines, the five button lines and the frame tick. A beat can be
// taken in every cycle while full is low; full rises only when the report
// queue holds QueueDepth unsent reports.
// Result channel (empty / pop): a frame tick yields 19 beats, ten button
// symbols, eight count symbols (least significant first) and a split marker
// with last_o set. A ticked sample's report is written into the queue and
// then loaded into the output register once that is idle or its split marker
// leaves; one symbol leaves per cycle while pop is high, and back-to-back
// reports follow without a gap.
// Phase and strobe edges are decoded in the cycle a sample is taken, whatever
// the output is doing. When the receiver stalls, finished reports wait in the
// queue; samples keep flowing until it is full.
// Reset clears the count, the captured groups and the queue. The first sample
// after reset does not step the count; it only loads the phase levels.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_roller_frame_reporter import qrfr_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       phase_a_i,
  input  wire logic       phase_b_i,
  input  wire logic       strobe_first_i,
  input  wire logic       strobe_second_i,
  input  wire logic [4:0] button_lines_i,
  input  wire logic       frame_tick_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      symbol_o,
  output logic            last_o
);

  logic    accept, rep_valid, head_valid, head_take;
  report_t rep, head;

  assign accept = push && !full;

  qrfr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .phase_a_i       (phase_a_i),
    .phase_b_i       (phase_b_i),
    .strobe_first_i  (strobe_first_i),
    .strobe_second_i (strobe_second_i),
    .button_lines_i  (button_lines_i),
    .frame_tick_i    (frame_tick_i),
    .rep_valid_o     (rep_valid),
    .rep_o           (rep)
  );

  qrfr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rep_valid),
    .wr_data_i (rep),
    .rd_i      (head_take),
    .full_o    (full),
    .valid_o   (head_valid),
    .rd_data_o (head)
  );

  qrfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_take_o  (head_take),
    .pop_i        (pop),
    .empty_o      (empty),
    .symbol_o     (symbol_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// File: sv/qrfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module qrfr_checker import qrfr_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [1:0] symbol_o,
  input wire logic       last_o
);

  // The split marker and last travel together, and nothing else is flagged last.
  a_split_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((symbol_o == SYM_SPLIT) == last_o))
    else $error("split marker and last disagree");

  a_no_bad_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (symbol_o == SYM_ZERO || symbol_o == SYM_ONE || symbol_o == SYM_SPLIT))
    else $error("undefined symbol code shown");

  // A report runs on without a break: after a non-final beat another follows.
  a_report_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty)
    else $error("report cut short");

  a_held_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(symbol_o) && $stable(last_o)))
    else $error("stalled beat changed");

endmodule

bind quadrature_roller_frame_reporter qrfr_checker u_qrfr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .symbol_o (symbol_o),
  .last_o   (last_o)
);

`default_nettype wire

// File: tb/tb_quadrature_roller_frame_reporter.sv
`timescale 1ns / 1ps

module tb_quadrature_roller_frame_reporter;
  import qrfr_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned SettleCycles = 20;

  typedef struct packed {
    logic       phase_a;
    logic       phase_b;
    logic       strobe_first;
    logic       strobe_second;
    logic [4:0] button_lines;
    logic       frame_tick;
  } sample_t;

  typedef struct packed {
    sym_e symbol;
    logic last;
  } report_beat_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       push            = 1'b0;
  logic       pop             = 1'b0;
  logic       phase_a_i       = 1'b0;
  logic       phase_b_i       = 1'b0;
  logic       strobe_first_i  = 1'b0;
  logic       strobe_second_i = 1'b0;
  logic [4:0] button_lines_i  = 5'd0;
  logic       frame_tick_i    = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] symbol_o;
  logic       last_o;

  // Own copy of the decoder state, updated as each sample beat is taken.
  logic       seen_phase_a   = 1'b0;
  logic       seen_phase_b   = 1'b0;
  logic       phases_loaded  = 1'b0;
  logic [7:0] roll_q         = 8'd0;
  logic       seen_strobe_1  = 1'b0;
  logic       seen_strobe_2  = 1'b0;
  logic [4:0] group_first_q  = 5'd0;
  logic [4:0] group_second_q = 5'd0;

  report_beat_t expected_symbols[$];
  sample_t      last_sent = '0;

  int unsigned errors          = 0;
  int unsigned samples_sent    = 0;
  int unsigned reports_due     = 0;
  int unsigned reports_seen    = 0;
  int unsigned symbols_checked = 0;
  int unsigned held_off_cycles = 0;
  int unsigned quiet_cycles    = 0;

  // Pacing of both sides; the tests change these as they go.
  int unsigned tx_max_gap = 0;
  int unsigned burst_left = 0;
  int unsigned max_stall  = 0;
  int unsigned stall_left = 0;

  quadrature_roller_frame_reporter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .phase_a_i      (phase_a_i),
    .phase_b_i      (phase_b_i),
    .strobe_first_i (strobe_first_i),
    .strobe_second_i(strobe_second_i),
    .button_lines_i (button_lines_i),
    .frame_tick_i   (frame_tick_i),
    .empty          (empty),
    .pop            (pop),
    .symbol_o       (symbol_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Steps the roll count, captures button groups and queues the report that a tick causes.
  function automatic void predict_report(sample_t s);
    logic [17:0]  frame_bits;
    report_beat_t beat;
    if (!phases_loaded) begin
      phases_loaded = 1'b1;
    end else if ((s.phase_a != seen_phase_a) && (s.phase_b == seen_phase_b)) begin
      roll_q = (s.phase_a != s.phase_b) ? roll_q + 8'd1 : roll_q - 8'd1;
    end else if ((s.phase_b != seen_phase_b) && (s.phase_a == seen_phase_a)) begin
      roll_q = (s.phase_b == s.phase_a) ? roll_q + 8'd1 : roll_q - 8'd1;
    end
    seen_phase_a = s.phase_a;
    seen_phase_b = s.phase_b;
    if (s.strobe_first && !seen_strobe_1) begin
      group_first_q = s.button_lines;
    end
    if (s.strobe_second && !seen_strobe_2) begin
      group_second_q = s.button_lines;
    end
    seen_strobe_1 = s.strobe_first;
    seen_strobe_2 = s.strobe_second;
    if (s.frame_tick) begin
      frame_bits = {roll_q, group_second_q, group_first_q};
      beat.last  = 1'b0;
      for (int i = 0; i < 18; i++) begin
        // Button lines are active low, so a set line reads as a zero mark.
        if (i < 10) begin
          beat.symbol = frame_bits[i] ? SYM_ZERO : SYM_ONE;
        end else begin
          beat.symbol = frame_bits[i] ? SYM_ONE : SYM_ZERO;
        end
        expected_symbols.push_back(beat);
      end
      beat.symbol = SYM_SPLIT;
      beat.last   = 1'b1;
      expected_symbols.push_back(beat);
      roll_q = 8'd0;
      reports_due++;
    end
  endfunction

  function automatic int unsigned phase_pos(logic a, logic b);
    case ({a, b})
      2'b00:   return 0;
      2'b10:   return 1;
      2'b11:   return 2;
      default: return 3;
    endcase
  endfunction

  task automatic send_sample(input logic a, input logic b, input logic s1, input logic s2,
                             input logic [4:0] btn, input logic tick);
    sample_t     s;
    int unsigned gap;
    s               = '{a, b, s1, s2, btn, tick};
    push            <= 1'b1;
    phase_a_i       <= a;
    phase_b_i       <= b;
    strobe_first_i  <= s1;
    strobe_second_i <= s2;
    button_lines_i  <= btn;
    frame_tick_i    <= tick;
    do @(posedge clk_i); while (full);
    predict_report(s);
    last_sent = s;
    samples_sent++;
    if (tx_max_gap != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap        = $urandom_range(1, tx_max_gap);
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Holds the sender off until every queued symbol has been taken.
  task automatic wait_for_reports();
    push <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk_i);
  endtask

  // Sends one quadrature step in the given direction, with quiet strobes.
  task automatic step_roller(input bit forward, input logic [4:0] btn, input logic tick);
    int unsigned pos;
    pos = (phase_pos(last_sent.phase_a, last_sent.phase_b) + (forward ? 1 : 3)) % 4;
    send_sample(pos == 1 || pos == 2, pos >= 2, 1'b0, 1'b0, btn, tick);
  endtask

  task automatic run_first_sample();
    tx_max_gap = 3;
    max_stall  = 6;
    // Both phases differ from their reset levels, but the first sample only loads them.
    send_sample(1'b1, 1'b1, 1'b1, 1'b0, 5'b10110, 1'b1);
    // Both phases change together: no step.
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 5'b11111, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0, 1'b0, 5'b00000, 1'b1);
  endtask

  task automatic run_phase_steps();
    send_sample(1'b1, 1'b0, 1'b1, 1'b0, 5'b00000, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1, 1'b0, 5'b11111, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0, 5'b11111, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0, 1'b0, 5'b11111, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0, 1'b0, 5'b11111, 1'b1);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0, 5'b01010, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0, 5'b01010, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0, 5'b01010, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0, 1'b0, 5'b01010, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0, 5'b01010, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0, 5'b01010, 1'b1);
  endtask

  task automatic run_edge_with_tick();
    // A step, both strobe edges and a tick in one beat: the report shows all of them.
    send_sample(1'b1, 1'b0, 1'b1, 1'b1, 5'b01001, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0, 5'b00000, 1'b1);
    send_sample(1'b1, 1'b1, 1'b1, 1'b1, 5'b10101, 1'b1);
  endtask

  task automatic run_count_wrap();
    tx_max_gap = 4;
    max_stall  = 10;
    send_sample(last_sent.phase_a, last_sent.phase_b, 1'b0, 1'b0, 5'd0, 1'b1);
    // Far enough forward to pass +127 and wrap to negative values.
    for (int n = 0; n < 129; n++) begin
      step_roller(1'b1, 5'($urandom_range(0, 31)), 1'b0);
    end
    send_sample(last_sent.phase_a, last_sent.phase_b, 1'b0, 1'b0, 5'd0, 1'b1);
  endtask

  task automatic run_random_samples(input int unsigned count);
    int unsigned pos;
    int unsigned pick;
    bit          forward;
    forward = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      // The first stretch runs with neither side idling.
      if (n == 0) begin
        tx_max_gap = 0;
        max_stall  = 0;
      end else if (n == count / 4) begin
        tx_max_gap = 6;
        max_stall  = 24;
      end else if (n == count / 2) begin
        wait_for_reports();
      end
      if ($urandom_range(0, 15) == 0) begin
        forward = !forward;
      end
      pos  = phase_pos(last_sent.phase_a, last_sent.phase_b);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        pos = pos + (forward ? 1 : 3);
      end else if (pick < 75) begin
        pos = pos + (forward ? 3 : 1);
      end else if (pick < 83) begin
        pos = pos + 2;
      end
      pos = pos % 4;
      send_sample(pos == 1 || pos == 2, pos >= 2, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                  $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic run_backpressure();
    // A tick on every beat against a slow receiver fills the report queue.
    tx_max_gap = 0;
    max_stall  = 40;
    for (int n = 0; n < 10; n++) begin
      if ($urandom_range(0, 1) == 1) begin
        step_roller($urandom_range(0, 1) == 1, 5'($urandom_range(0, 31)), 1'b1);
      end else begin
        send_sample(last_sent.phase_a, last_sent.phase_b, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), 1'b1);
      end
    end
    wait_for_reports();
    max_stall = 8;
  endtask

  // Result side: checks each symbol beat and drives pop on its own stall pattern.
  always @(posedge clk_i) begin
    report_beat_t want;
    if (pop && !empty) begin
      if (expected_symbols.size() == 0) begin
        $error("unexpected symbol beat: symbol %0d, last %0d", symbol_o, last_o);
        errors++;
      end else begin
        want = expected_symbols.pop_front();
        if (symbol_o !== want.symbol) begin
          $error("symbol: expected %0d, actual %0d", want.symbol, symbol_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          errors++;
        end
        symbols_checked++;
        if (want.last) begin
          reports_seen++;
        end
      end
    end
    if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if (max_stall != 0 && $urandom_range(0, 3) == 0) begin
      pop <= 1'b0;
      stall_left = $urandom_range(0, max_stall - 1);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (push && full) begin
      held_off_cycles++;
    end
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Timed out after %0d cycles without a beat.", quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_first_sample();
    run_phase_steps();
    run_edge_with_tick();
    run_count_wrap();
    run_random_samples(16);
    run_backpressure();
    wait_for_reports();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d samples; %0d frame reports predicted, %0d seen, %0d symbols checked.",
             samples_sent, reports_due, reports_seen, symbols_checked);
    $display("Covered both step directions, invalid steps, count wrap and %0d held-off cycles.",
             held_off_cycles);
    if (errors == 0 && expected_symbols.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/qrfr_pkg.sv
sv/qrfr_front.sv
sv/qrfr_fifo.sv
sv/qrfr_back.sv
sv/quadrature_roller_frame_reporter.sv
sv/qrfr_checker.sv
tb/tb_quadrature_roller_frame_reporter.sv
